/* rtl/tpce_pkg.sv */
// tpce_pkg: shared types and constants of the tour permutation cost enumerator
// used by tpce_order_mem, tpce_ctrl and the top module; no dependencies

package tpce_pkg;

  localparam int CITY_W     = 4;   // city number and tour position
  localparam int CNT_W      = 5;   // city count, up to sixteen
  localparam int DIN_W      = 16;  // distance word on the input
  localparam int COST_W     = 20;
  localparam int PACK_W     = 64;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 88;
  localparam int ACT_W      = 2;
  localparam int REG_IDX_W  = 2;
  localparam int REG_DATA_W = 5;

  localparam logic [COST_W-1:0] COST_MAX   = 20'hFFFFF;
  localparam logic [CITY_W-1:0] PREFIX_LEN = 4'd2;

  // input word kinds
  localparam logic [ACT_W-1:0] ACT_LOAD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_START   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ADVANCE = 2'd2;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_CITY_COUNT  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PREFIX_MODE = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PREFIX_CITY = 2'd2;

  localparam logic [CNT_W-1:0]  CITY_COUNT_RST  = 5'd5;
  localparam logic [CITY_W-1:0] PREFIX_CITY_RST = 4'd1;

  // configuration after range fixing
  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic              prefix_on;
    logic [CITY_W-1:0] first_city;
  } run_cfg_t;

  // order memory access
  typedef struct packed {
    logic              rd_en;
    logic [CITY_W-1:0] rd_addr;
    logic              wr_en;
    logic [CITY_W-1:0] wr_addr;
    logic [CITY_W-1:0] wr_data;
    logic              clr;
  } ord_req_t;

endpackage

/* rtl/tpce_dist_mem.sv */
// tpce_dist_mem: distance table, one write and one registered read port
// depends on nothing; entries hold no reset value

module tpce_dist_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 16,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/tpce_order_mem.sv */
// tpce_order_mem: current tour order, one write and one registered read port
// depends on tpce_pkg; an entry with its valid bit clear reads as its own position

module tpce_order_mem #(
  parameter int MAX_CITIES = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  tpce_pkg::ord_req_t        req,
  output logic [tpce_pkg::CITY_W-1:0] rd_data
);

  import tpce_pkg::*;

  localparam int PW = $clog2(MAX_CITIES);

  logic [CITY_W-1:0]     mem [MAX_CITIES];
  logic [MAX_CITIES-1:0] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.clr) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.wr_addr[PW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[PW-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= valid[req.rd_addr[PW-1:0]] ? mem[req.rd_addr[PW-1:0]] : req.rd_addr;
    end
  end

endmodule

/* rtl/tpce_ctrl.sv */
// tpce_ctrl: sequencer for loads, first tour, next permutation and cost pass
// depends on tpce_pkg; drives the distance and order memories, owns the output register

module tpce_ctrl #(
  parameter int MAX_CITIES = 16,
  parameter int DIST_BITS  = 16,
  parameter int AW         = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  tpce_pkg::run_cfg_t                 cfg,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [tpce_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic [tpce_pkg::ACT_W-1:0]         s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [tpce_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic [0:0]                         m_tuser,
  output tpce_pkg::ord_req_t                 ord,
  input  logic [tpce_pkg::CITY_W-1:0]        ord_rd_data,
  output logic                               dist_wr_en,
  output logic [AW-1:0]                      dist_wr_addr,
  output logic [DIST_BITS-1:0]               dist_wr_data,
  output logic                               dist_rd_en,
  output logic [AW-1:0]                      dist_rd_addr,
  input  logic [DIST_BITS-1:0]               dist_rd_data
);

  import tpce_pkg::*;

  localparam int ACC_W = (DIST_BITS + 4 > COST_W) ? DIST_BITS + 4 : COST_W + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_FILL, S_SCAN, S_FIND, S_SWAP_I, S_SWAP_J,
    S_REV_RD_LO, S_REV_RD_HI, S_REV_WR_LO, S_REV_WR_HI,
    S_INIT_COST, S_COST, S_CLOSE, S_DRAIN, S_DONE
  } state_t;

  state_t state;

  logic [CITY_W-1:0] pos, rd_pos, right, pivot, pivot_val, jpos, succ;
  logic [CITY_W-1:0] lo, hi, tmp, first, prev;
  logic              rd_pend, dist_pend, have_right, iss_done, wrapped;
  logic [ACC_W-1:0]  acc;
  logic [PACK_W-1:0] packed_ord;
  logic [COST_W-1:0] m_cost;
  logic [PACK_W-1:0] m_packed;
  logic              m_wrapped;

  logic              in_acc;
  logic [CITY_W-1:0] last, off, fill_val, d;
  logic [CITY_W-1:0] ld_from, ld_to;

  function automatic logic [AW-1:0] pair_addr(input logic [CITY_W-1:0] a,
                                              input logic [CITY_W-1:0] b);
    return AW'(int'(a) * MAX_CITIES + int'(b));
  endfunction

  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign ld_from  = s_tdata[3:0];
  assign ld_to    = s_tdata[7:4];
  assign d        = ord_rd_data;
  assign last     = CITY_W'(cfg.count - 5'd1);
  assign off      = cfg.prefix_on ? PREFIX_LEN : '0;

  // prefix fill: position one gets the prefix city, the rest ascend around it
  assign fill_val = (pos == 4'd1) ? cfg.first_city :
                    ((pos - 4'd1) < cfg.first_city) ? pos - 4'd1 : pos;

  assign m_tdata  = {{(OUT_DATA_W - PACK_W - COST_W){1'b0}}, m_packed, m_cost};
  assign m_tuser  = m_wrapped;

  always_comb begin
    ord          = '0;
    dist_wr_en   = 1'b0;
    dist_wr_addr = pair_addr(ld_from, ld_to);
    dist_wr_data = DIST_BITS'(s_tdata[23:8]);
    dist_rd_en   = 1'b0;
    dist_rd_addr = pair_addr(prev, d);
    case (state)
      S_IDLE: begin
        ord.clr    = in_acc && (s_tuser == ACT_START);
        dist_wr_en = in_acc && (s_tuser == ACT_LOAD) &&
                     (int'(ld_from) < MAX_CITIES) && (int'(ld_to) < MAX_CITIES);
      end
      S_FILL: begin
        ord.wr_en   = 1'b1;
        ord.wr_addr = pos;
        ord.wr_data = fill_val;
      end
      S_SCAN: begin
        // no further read once the descent or the left end is seen
        ord.rd_en   = !(rd_pend && ((have_right && (d < right)) || (rd_pos == off)));
        ord.rd_addr = pos;
      end
      S_FIND: begin
        ord.rd_en   = !(rd_pend && (d > pivot_val));
        ord.rd_addr = pos;
      end
      S_SWAP_I: begin
        ord.wr_en   = 1'b1;
        ord.wr_addr = pivot;
        ord.wr_data = succ;
      end
      S_SWAP_J: begin
        ord.wr_en   = 1'b1;
        ord.wr_addr = jpos;
        ord.wr_data = pivot_val;
      end
      S_REV_RD_LO: begin
        ord.rd_en   = 1'b1;
        ord.rd_addr = lo;
      end
      S_REV_RD_HI: begin
        ord.rd_en   = 1'b1;
        ord.rd_addr = hi;
      end
      S_REV_WR_LO: begin
        ord.wr_en   = 1'b1;
        ord.wr_addr = lo;
        ord.wr_data = d;
      end
      S_REV_WR_HI: begin
        ord.wr_en   = 1'b1;
        ord.wr_addr = hi;
        ord.wr_data = tmp;
      end
      S_COST: begin
        ord.rd_en   = !iss_done;
        ord.rd_addr = pos;
        dist_rd_en  = rd_pend && (rd_pos != '0);
      end
      S_CLOSE: begin
        dist_rd_en   = 1'b1;
        dist_rd_addr = pair_addr(prev, first);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      m_tvalid  <= 1'b0;
      rd_pend   <= 1'b0;
      dist_pend <= 1'b0;
    end else begin
      rd_pend   <= ord.rd_en;
      rd_pos    <= ord.rd_addr;
      dist_pend <= dist_rd_en;
      if (dist_pend) begin
        acc <= acc + ACC_W'(dist_rd_data);
      end
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            case (s_tuser)
              ACT_START: begin
                wrapped <= 1'b0;
                pos     <= 4'd1;
                state   <= cfg.prefix_on ? S_FILL : S_INIT_COST;
              end
              ACT_ADVANCE: begin
                if ({1'b0, off} + 5'd1 >= cfg.count) begin
                  // single free position: nothing to permute
                  wrapped <= 1'b1;
                  state   <= S_INIT_COST;
                end else begin
                  wrapped    <= 1'b0;
                  pos        <= last;
                  have_right <= 1'b0;
                  state      <= S_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        S_FILL: begin
          pos <= pos + 4'd1;
          if (pos == last) begin
            state <= S_INIT_COST;
          end
        end
        S_SCAN: begin
          // walk leftward looking for the first descent
          if (rd_pend && have_right && (d < right)) begin
            pivot     <= rd_pos;
            pivot_val <= d;
            pos       <= last;
            state     <= S_FIND;
          end else begin
            pos <= (pos == off) ? pos : pos - 4'd1;
            if (rd_pend) begin
              if (rd_pos == off) begin
                // last permutation: reverse the whole free range
                wrapped <= 1'b1;
                lo      <= off;
                hi      <= last;
                state   <= S_REV_RD_LO;
              end else begin
                right      <= d;
                have_right <= 1'b1;
              end
            end
          end
        end
        S_FIND: begin
          pos <= pos - 4'd1;
          if (rd_pend && (d > pivot_val)) begin
            jpos    <= rd_pos;
            succ    <= d;
            state   <= S_SWAP_I;
          end
        end
        S_SWAP_I: begin
          state <= S_SWAP_J;
        end
        S_SWAP_J: begin
          lo    <= pivot + 4'd1;
          hi    <= last;
          state <= ((pivot + 4'd1) < last) ? S_REV_RD_LO : S_INIT_COST;
        end
        S_REV_RD_LO: begin
          state <= S_REV_RD_HI;
        end
        S_REV_RD_HI: begin
          tmp   <= d;
          state <= S_REV_WR_LO;
        end
        S_REV_WR_LO: begin
          state <= S_REV_WR_HI;
        end
        S_REV_WR_HI: begin
          lo    <= lo + 4'd1;
          hi    <= hi - 4'd1;
          state <= ((lo + 4'd1) < (hi - 4'd1)) ? S_REV_RD_LO : S_INIT_COST;
        end
        S_INIT_COST: begin
          pos        <= '0;
          iss_done   <= 1'b0;
          acc        <= '0;
          packed_ord <= '0;
          state      <= S_COST;
        end
        S_COST: begin
          if (!iss_done) begin
            pos <= pos + 4'd1;
            if (pos == last) begin
              iss_done <= 1'b1;
            end
          end
          if (rd_pend) begin
            packed_ord[{rd_pos, 2'b00} +: CITY_W] <= d;
            prev <= d;
            if (rd_pos == '0) begin
              first <= d;
            end
            if (rd_pos == last) begin
              state <= S_CLOSE;
            end
          end
        end
        S_CLOSE: begin
          state <= S_DRAIN;
        end
        S_DRAIN: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid  <= 1'b1;
            m_cost    <= (acc > ACC_W'(COST_MAX)) ? COST_MAX : acc[COST_W-1:0];
            m_packed  <= packed_ord;
            m_wrapped <= wrapped;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // successor search never reaches the pivot
  a_find_right_of_pivot: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIND && rd_pend) |-> (rd_pos > pivot))
    else $error("successor search passed the pivot");

  // pivot scan stays inside the free range
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && rd_pend) |-> (rd_pos >= off))
    else $error("pivot scan left the free range");

  // a swap of the reversal always has two distinct ends
  a_rev_ordered: assert property (@(posedge clk) disable iff (rst)
    (state == S_REV_RD_LO) |-> (lo < hi))
    else $error("reversal ends crossed");

  // a result word is only raised at the end of a cost pass
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_DONE))
    else $error("result raised outside of completion");

endmodule

/* rtl/tour_permutation_cost_enumerator_top.sv */
// tour_permutation_cost_enumerator_top: configuration registers and memory hookup
// depends on tpce_pkg, tpce_ctrl, tpce_dist_mem, tpce_order_mem
// load word: written into the distance table. start: cost pass, after the order is written in prefix mode.
// advance: pivot scan, successor scan, swap, reversal pair by pair, then the cost
// pass, all paced by the single read port of the order memory. one word is worked
// on at a time.
// reset is synchronous: order returns to identity at once, table stays undefined.

module tour_permutation_cost_enumerator_top #(
  parameter int MAX_CITIES = 16,
  parameter int DIST_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // from_city[3:0], to_city[7:4], distance_value[23:8]
  input  logic [tpce_pkg::IN_DATA_W-1:0]      s_tdata,
  // action[1:0]
  input  logic [tpce_pkg::ACT_W-1:0]          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // tour_cost[19:0], tour_packed[83:20], zero fill[87:84]
  output logic [tpce_pkg::OUT_DATA_W-1:0]     m_tdata,
  // wrapped[0]
  output logic [0:0]                          m_tuser,
  input  logic                                cfg_wr_en,
  input  logic [tpce_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [tpce_pkg::REG_DATA_W-1:0]     cfg_data
);

  import tpce_pkg::*;

  localparam int DEPTH = MAX_CITIES * MAX_CITIES;
  localparam int AW    = $clog2(DEPTH);

  logic [CNT_W-1:0]  city_count;
  logic              prefix_mode;
  logic [CITY_W-1:0] prefix_city;
  logic [CNT_W-1:0]  n_eff;
  run_cfg_t          run_cfg;

  ord_req_t          ord;
  logic [CITY_W-1:0] ord_rd_data;
  logic              dist_wr_en, dist_rd_en;
  logic [AW-1:0]     dist_wr_addr, dist_rd_addr;
  logic [DIST_BITS-1:0] dist_wr_data, dist_rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      city_count  <= CITY_COUNT_RST;
      prefix_mode <= 1'b0;
      prefix_city <= PREFIX_CITY_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CITY_COUNT:  city_count  <= cfg_data;
        REG_PREFIX_MODE: prefix_mode <= cfg_data[0];
        REG_PREFIX_CITY: prefix_city <= cfg_data[CITY_W-1:0];
        default: ;
      endcase
    end
  end

  // count held to 3..MAX_CITIES, bad prefix city falls back to city one
  always_comb begin
    if (city_count < 5'd3) begin
      n_eff = 5'd3;
    end else if (int'(city_count) > MAX_CITIES) begin
      n_eff = CNT_W'(MAX_CITIES);
    end else begin
      n_eff = city_count;
    end
    run_cfg.count      = n_eff;
    run_cfg.prefix_on  = prefix_mode;
    run_cfg.first_city = ((prefix_city == '0) || ({1'b0, prefix_city} >= n_eff)) ?
                         4'd1 : prefix_city;
  end

  tpce_ctrl #(
    .MAX_CITIES (MAX_CITIES),
    .DIST_BITS  (DIST_BITS),
    .AW         (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg          (run_cfg),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .ord          (ord),
    .ord_rd_data  (ord_rd_data),
    .dist_wr_en   (dist_wr_en),
    .dist_wr_addr (dist_wr_addr),
    .dist_wr_data (dist_wr_data),
    .dist_rd_en   (dist_rd_en),
    .dist_rd_addr (dist_rd_addr),
    .dist_rd_data (dist_rd_data)
  );

  tpce_dist_mem #(
    .DEPTH (DEPTH),
    .WIDTH (DIST_BITS),
    .AW    (AW)
  ) u_dist_mem (
    .clk     (clk),
    .wr_en   (dist_wr_en),
    .wr_addr (dist_wr_addr),
    .wr_data (dist_wr_data),
    .rd_en   (dist_rd_en),
    .rd_addr (dist_rd_addr),
    .rd_data (dist_rd_data)
  );

  tpce_order_mem #(
    .MAX_CITIES (MAX_CITIES)
  ) u_order_mem (
    .clk     (clk),
    .rst     (rst),
    .req     (ord),
    .rd_data (ord_rd_data)
  );

endmodule
